// ===== design/gmmcs_pkg.sv =====
// Shared constants and types for the gray min/max contrast stretch block.
package gmmcs_pkg;

    localparam int LEVEL_W = 8;
    localparam int COLOR_W = 8;
    localparam int COEF_W  = 10;
    localparam int SUM_W   = 18;

    localparam logic [COEF_W-1:0] GRAY_WR = 10'd299;
    localparam logic [COEF_W-1:0] GRAY_WG = 10'd587;
    localparam logic [COEF_W-1:0] GRAY_WB = 10'd114;

    // floor(sum / 1000) == (sum * RECIP) >> RECIP_SHIFT for every sum up to 255000
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 19'd268436;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // map word handed from front to back, with the frame bounds seen at its turn
    typedef struct packed {
        logic [LEVEL_W-1:0] gray;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
    } q_entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

// ===== design/gmmcs_front.sv =====
// Front end: gray conversion, frame min/max tracking, dispatch of map words.
module gmmcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic                          in_sof,
    input  logic [gmmcs_pkg::COLOR_W-1:0] in_red,
    input  logic [gmmcs_pkg::COLOR_W-1:0] in_green,
    input  logic [gmmcs_pkg::COLOR_W-1:0] in_blue,
    output logic                          push,
    output gmmcs_pkg::q_entry_t           push_data,
    input  logic                          q_full
);
    import gmmcs_pkg::*;

    logic               a_valid_reg;
    logic               a_op_reg;
    logic               a_sof_reg;
    logic [SUM_W-1:0]   a_sum_reg;
    logic               b_valid_reg;
    logic               b_op_reg;
    logic               b_sof_reg;
    logic [LEVEL_W-1:0] b_gray_reg;
    logic [LEVEL_W-1:0] min_reg;
    logic [LEVEL_W-1:0] max_reg;

    logic [SUM_W-1:0]   sum_next;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] gray_next;
    logic               span_ok;
    logic               want_push;
    logic               stall;
    logic               take;
    logic [LEVEL_W-1:0] base_min;
    logic [LEVEL_W-1:0] base_max;
    logic [LEVEL_W-1:0] min_next;
    logic [LEVEL_W-1:0] max_next;

    assign sum_next = SUM_W'(in_red) * SUM_W'(GRAY_WR)
                    + SUM_W'(in_green) * SUM_W'(GRAY_WG)
                    + SUM_W'(in_blue) * SUM_W'(GRAY_WB);

    assign prod      = PROD_W'(a_sum_reg) * PROD_W'(RECIP);
    assign gray_next = prod[RECIP_SHIFT +: LEVEL_W];

    assign span_ok   = max_reg > min_reg;
    assign want_push = b_valid_reg && b_op_reg && span_ok;
    // whole pipe holds only when a map word cannot enter the queue
    assign stall     = want_push && q_full;
    assign in_ready  = !stall;
    assign take      = in_valid && !stall;
    assign push      = want_push && !q_full;

    assign push_data.gray = b_gray_reg;
    assign push_data.lo   = min_reg;
    assign push_data.hi   = max_reg;

    assign base_min = b_sof_reg ? LEVEL_MAX : min_reg;
    assign base_max = b_sof_reg ? LEVEL_MIN : max_reg;
    assign min_next = (b_gray_reg < base_min) ? b_gray_reg : base_min;
    assign max_next = (b_gray_reg > base_max) ? b_gray_reg : base_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            min_reg     <= LEVEL_MAX;
            max_reg     <= LEVEL_MIN;
        end
        else
        begin
            if (!stall)
            begin
                a_valid_reg <= take;
                b_valid_reg <= a_valid_reg;
            end
            if (b_valid_reg && !b_op_reg)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a_op_reg   <= in_op;
            a_sof_reg  <= in_sof;
            a_sum_reg  <= sum_next;
            b_op_reg   <= a_op_reg;
            b_sof_reg  <= a_sof_reg;
            b_gray_reg <= gray_next;
        end
    end

endmodule

// ===== design/gmmcs_fifo.sv =====
// Short queue of map words between front and back end.
module gmmcs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gmmcs_pkg::q_entry_t push_data,
    input  logic                pop,
    output gmmcs_pkg::q_entry_t pop_data,
    output gmmcs_pkg::q_stat_t  stat
);
    import gmmcs_pkg::*;

    q_entry_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign stat.count = count_reg;
    assign stat.full  = count_reg == QCNT_W'(QDEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/gmmcs_back.sv =====
// Back end: clamps gray to the frame bounds, divides serially, holds the output word.
module gmmcs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  gmmcs_pkg::q_entry_t           q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gmmcs_pkg::LEVEL_W-1:0] out_level
);
    import gmmcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    localparam int CNT_W = $clog2(LEVEL_W);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [LEVEL_W-1:0]     rem_reg;
    logic [LEVEL_W-1:0]     quo_reg;
    logic [LEVEL_W-1:0]     span_reg;
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     out_level_reg;

    logic [LEVEL_W-1:0]     g_clamp;
    logic [LEVEL_W-1:0]     diff;
    logic [2*LEVEL_W-1:0]   numer;
    logic [LEVEL_W:0]       trial;
    logic                   ge;
    logic [LEVEL_W:0]       trial_sub;
    logic                   load_out;

    // clamping to hi makes the quotient come out as exactly 255
    assign g_clamp = (q_data.gray <= q_data.lo) ? q_data.lo :
                     (q_data.gray >= q_data.hi) ? q_data.hi : q_data.gray;
    assign diff    = g_clamp - q_data.lo;
    assign numer   = {diff, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, diff};

    // restoring step: remainder stays below span, quotient fits in 8 bits
    assign trial     = {rem_reg, quo_reg[LEVEL_W-1]};
    assign ge        = trial >= {1'b0, span_reg};
    assign trial_sub = trial - {1'b0, span_reg};

    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (cnt_reg == CNT_W'(LEVEL_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                cnt_reg <= '0;
            else if (state_reg == ST_CALC)
                cnt_reg <= cnt_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg  <= numer[2*LEVEL_W-1:LEVEL_W];
            quo_reg  <= numer[LEVEL_W-1:0];
            span_reg <= q_data.hi - q_data.lo;
        end
        else if (state_reg == ST_CALC)
        begin
            rem_reg <= ge ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            quo_reg <= {quo_reg[LEVEL_W-2:0], ge};
        end
        if (load_out)
            out_level_reg <= quo_reg;
    end

endmodule

// ===== design/gray_min_max_contrast_stretch.sv =====
// Top level of the gray min/max contrast stretch: front end, word queue, back end.
//
//   channel | dir | handshake         | tdata / tuser
//   s_      | in  | s_tvalid/s_tready | tdata red,green,blue; tuser operation,start_of_frame
//   m_      | out | m_tvalid/m_tready | tdata stretched_level
//
// Measure words and dropped map words pass pipe registers a and b and cause no stall themselves.
// Back end per map word: load, 8 serial divide steps, output load, then the next word is popped;
// the serial divider sets the sustained rate for map passes, a 4-word queue decouples it.
// Reset sets frame min to 255 and max to 0 and empties queue and output register.
// s_tready drops only while a map word waits on a full queue.
module gray_min_max_contrast_stretch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic [1:0]  s_tuser,   // operation [0], start_of_frame [1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // stretched_level [7:0]
);
    import gmmcs_pkg::*;

    logic     push;
    q_entry_t push_data;
    logic     pop;
    q_entry_t pop_data;
    q_stat_t  q_stat;

    gmmcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_sof    (s_tuser[1]),
        .in_red    (s_tdata[7:0]),
        .in_green  (s_tdata[15:8]),
        .in_blue   (s_tdata[23:16]),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_stat.full)
    );

    gmmcs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    gmmcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_stat.empty),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_level (m_tdata)
    );

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_stat.full)
        else $error("input stalled with room in queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_pop_filled: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
